FILE: rtl/hlbc_pkg.sv
// Shared constants for the hashed LRU buffer cache tag store.
// Command and status codes, field widths and parameter defaults.
package hlbc_pkg;

  localparam int unsigned NUM_SLOTS_DEF   = 32;
  localparam int unsigned NUM_BUCKETS_DEF = 13;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned DEV_W = 8;
  localparam int unsigned BLK_W = 32;
  localparam int unsigned IDX_W = 5;
  localparam int unsigned CNT_W = 8;
  localparam int unsigned STS_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  localparam logic [CMD_W-1:0] CMD_GET     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PIN     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNPIN   = 2'd3;

  localparam logic [STS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STS_NO_BUFFER = 2'd1;
  localparam logic [STS_W-1:0] STS_UNDERFLOW = 2'd2;

endpackage

FILE: rtl/hashed_lru_buffer_cache.sv
// Hashed LRU buffer cache tag store: slot memory, bucket list heads and tails, control.
// Depends on hlbc_pkg.
//
// A request is taken when start is high and busy is low; its single result
// shows for one cycle with valid_o high and cannot be held off. After reset
// the block sweeps the slot memory, one slot a cycle, with busy high. Pin and
// unpin read the slot and update its count in S_CMD. Get and release hash
// the block number (4 bits a cycle). A get then walks the home bucket one
// slot a cycle through the slot memory read port; on a miss it walks buckets
// from the back for a free slot (one slot a cycle, with an S_FSTRT step per
// bucket), and moving a slot between lists takes S_DET1, S_DET2, S_PUT1 and
// S_PUT2. A release that frees a slot hashes its stored block number and
// moves the slot to the front of its home bucket.
module hashed_lru_buffer_cache
  import hlbc_pkg::*;
#(
  parameter int unsigned NUM_SLOTS   = NUM_SLOTS_DEF,
  parameter int unsigned NUM_BUCKETS = NUM_BUCKETS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [CMD_W-1:0] cmd_i,
  input  logic [DEV_W-1:0] device_id_i,
  input  logic [BLK_W-1:0] block_number_i,
  input  logic [IDX_W-1:0] slot_index_i,
  output logic             valid_o,
  output logic [IDX_W-1:0] buffer_slot_o,
  output logic             hit_o,
  output logic             needs_read_o,
  output logic [STS_W-1:0] status_o
);

  localparam int unsigned SW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned KW = $clog2(NUM_BUCKETS + 1);
  localparam int unsigned XW = SW + 6;
  localparam logic [SW-1:0] NO_SLOT = SW'(NUM_SLOTS);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_LOOK  = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_FSTRT = 4'd5;
  localparam logic [3:0] S_FSCAN = 4'd6;
  localparam logic [3:0] S_CMD   = 4'd7;
  localparam logic [3:0] S_DET1  = 4'd8;
  localparam logic [3:0] S_DET2  = 4'd9;
  localparam logic [3:0] S_PUT1  = 4'd10;
  localparam logic [3:0] S_PUT2  = 4'd11;

  logic [DEV_W-1:0] mem_dev [NUM_SLOTS];
  logic [BLK_W-1:0] mem_blk [NUM_SLOTS];
  logic             mem_vld [NUM_SLOTS];
  logic [CNT_W-1:0] mem_cnt [NUM_SLOTS];
  logic [SW-1:0]    mem_lb  [NUM_SLOTS];
  logic [SW-1:0]    mem_lf  [NUM_SLOTS];

  logic [DEV_W-1:0] rd_dev_q;
  logic [BLK_W-1:0] rd_blk_q;
  logic             rd_vld_q;
  logic [CNT_W-1:0] rd_cnt_q;
  logic [SW-1:0]    rd_lb_q, rd_lf_q;

  logic [AW-1:0]    ra, wa;
  logic             we_tag, we_vld, we_cnt, we_lb, we_lf;
  logic [DEV_W-1:0] wd_dev;
  logic [BLK_W-1:0] wd_blk;
  logic             wd_vld;
  logic [CNT_W-1:0] wd_cnt;
  logic [SW-1:0]    wd_lb, wd_lf;

  logic [SW-1:0] front_q [NUM_BUCKETS];
  logic [SW-1:0] front_d [NUM_BUCKETS];
  logic [SW-1:0] back_q  [NUM_BUCKETS];
  logic [SW-1:0] back_d  [NUM_BUCKETS];

  logic [3:0]       state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [CMD_W-1:0] cmd_q, cmd_d;
  logic [DEV_W-1:0] dev_q, dev_d;
  logic [BLK_W-1:0] blk_q, blk_d;
  logic [SW-1:0]    cur_q, cur_d, p_q, p_d, n_q, n_d, old_q, old_d;
  logic [BW-1:0]    home_q, home_d, bidx_q, bidx_d;
  logic [KW-1:0]    k_q, k_d;
  logic [BLK_W-1:0] hv_q, hv_d;
  logic [BW-1:0]    hr_q, hr_d;
  logic [2:0]       hcnt_q, hcnt_d;

  logic             valid_q, valid_d, hit_q, hit_d, rdn_q, rdn_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic [STS_W-1:0] sts_q, sts_d;

  logic [XW-1:0] clr_x;
  logic [BW:0]   ht;
  logic [BW-1:0] hr_n;
  logic [SW-1:0] sel;

  always_ff @(posedge clk_i) begin
    if (we_tag) begin
      mem_dev[wa] <= wd_dev;
      mem_blk[wa] <= wd_blk;
    end
    if (we_vld) mem_vld[wa] <= wd_vld;
    if (we_cnt) mem_cnt[wa] <= wd_cnt;
    if (we_lb)  mem_lb[wa]  <= wd_lb;
    if (we_lf)  mem_lf[wa]  <= wd_lf;
    rd_dev_q <= mem_dev[ra];
    rd_blk_q <= mem_blk[ra];
    rd_vld_q <= mem_vld[ra];
    rd_cnt_q <= mem_cnt[ra];
    rd_lb_q  <= mem_lb[ra];
    rd_lf_q  <= mem_lf[ra];
  end

  always_comb begin
    ht   = '0;
    hr_n = hr_q;
    for (int j = 0; j < 4; j++) begin
      ht = {hr_n, hv_q[BLK_W-1-j]};
      if (ht >= (BW+1)'(NUM_BUCKETS)) ht = ht - (BW+1)'(NUM_BUCKETS);
      hr_n = ht[BW-1:0];
    end
  end

  assign clr_x = XW'(clr_q);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cmd_d   = cmd_q;
    dev_d   = dev_q;
    blk_d   = blk_q;
    cur_d   = cur_q;
    p_d     = p_q;
    n_d     = n_q;
    old_d   = old_q;
    home_d  = home_q;
    bidx_d  = bidx_q;
    k_d     = k_q;
    hv_d    = hv_q;
    hr_d    = hr_q;
    hcnt_d  = hcnt_q;
    front_d = front_q;
    back_d  = back_q;
    valid_d = 1'b0;
    hit_d   = hit_q;
    rdn_d   = rdn_q;
    slot_d  = slot_q;
    sts_d   = sts_q;
    sel     = NO_SLOT;

    ra     = AW'(cur_q);
    wa     = AW'(cur_q);
    we_tag = 1'b0;
    we_vld = 1'b0;
    we_cnt = 1'b0;
    we_lb  = 1'b0;
    we_lf  = 1'b0;
    wd_dev = dev_q;
    wd_blk = blk_q;
    wd_vld = 1'b1;
    wd_cnt = (rd_cnt_q == CNT_MAX) ? rd_cnt_q : rd_cnt_q + 1'b1;
    wd_lb  = n_q;
    wd_lf  = p_q;

    case (state_q)
      S_CLR: begin
        wa     = clr_q;
        we_tag = 1'b1;
        we_vld = 1'b1;
        we_cnt = 1'b1;
        we_lb  = 1'b1;
        we_lf  = 1'b1;
        wd_dev = '0;
        wd_blk = '0;
        wd_vld = 1'b0;
        wd_cnt = '0;
        wd_lb  = (clr_x >= XW'(NUM_BUCKETS)) ? SW'(clr_x - XW'(NUM_BUCKETS)) : NO_SLOT;
        wd_lf  = (clr_x + XW'(NUM_BUCKETS) < XW'(NUM_SLOTS)) ?
                 SW'(clr_x + XW'(NUM_BUCKETS)) : NO_SLOT;
        clr_d  = clr_q + 1'b1;
        if (clr_q == AW'(NUM_SLOTS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_d  = cmd_i;
          dev_d  = device_id_i;
          blk_d  = block_number_i;
          cur_d  = SW'(slot_index_i);
          hv_d   = block_number_i;
          hr_d   = '0;
          hcnt_d = '0;
          ra     = AW'(slot_index_i);
          if (cmd_i == CMD_GET) begin
            state_d = S_HASH;
          end else if (7'(slot_index_i) >= 7'(NUM_SLOTS)) begin
            valid_d = 1'b1;
            slot_d  = slot_index_i;
            hit_d   = 1'b0;
            rdn_d   = 1'b0;
            sts_d   = STS_OK;
          end else begin
            state_d = S_CMD;
          end
        end
      end
      S_CMD: begin
        p_d    = rd_lf_q;
        n_d    = rd_lb_q;
        slot_d = IDX_W'(cur_q);
        hit_d  = 1'b0;
        rdn_d  = 1'b0;
        sts_d  = STS_OK;
        if (cmd_q == CMD_PIN) begin
          we_cnt  = 1'b1;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else if (rd_cnt_q == '0) begin
          sts_d   = STS_UNDERFLOW;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          we_cnt = 1'b1;
          wd_cnt = rd_cnt_q - 1'b1;
          if (cmd_q == CMD_RELEASE && rd_cnt_q == CNT_W'(1)) begin
            hv_d    = rd_blk_q;
            state_d = S_HASH;
          end else begin
            valid_d = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_HASH: begin
        hv_d   = hv_q << 4;
        hr_d   = hr_n;
        hcnt_d = hcnt_q + 1'b1;
        if (hcnt_q == 3'd7) begin
          bidx_d  = hr_n;
          home_d  = hr_n;
          k_d     = '0;
          state_d = (cmd_q == CMD_GET) ? S_LOOK : S_DET1;
        end
      end
      S_LOOK: begin
        sel = front_q[bidx_q];
        if (sel == NO_SLOT) begin
          state_d = S_FSTRT;
        end else begin
          ra      = AW'(sel);
          cur_d   = sel;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_dev_q == dev_q && rd_blk_q == blk_q) begin
          we_cnt  = 1'b1;
          we_vld  = 1'b1;
          valid_d = 1'b1;
          slot_d  = IDX_W'(cur_q);
          hit_d   = 1'b1;
          rdn_d   = ~rd_vld_q;
          sts_d   = STS_OK;
          state_d = S_IDLE;
        end else if (rd_lb_q == NO_SLOT) begin
          state_d = S_FSTRT;
        end else begin
          ra    = AW'(rd_lb_q);
          cur_d = rd_lb_q;
        end
      end
      S_FSTRT, S_FSCAN: begin
        if (state_q == S_FSTRT) sel = back_q[bidx_q];
        else sel = rd_lf_q;
        if (state_q == S_FSCAN && rd_cnt_q == '0) begin
          p_d = rd_lf_q;
          n_d = rd_lb_q;
          if (k_q == '0) begin
            we_tag  = 1'b1;
            we_vld  = 1'b1;
            we_cnt  = 1'b1;
            wd_cnt  = CNT_W'(1);
            valid_d = 1'b1;
            slot_d  = IDX_W'(cur_q);
            hit_d   = 1'b0;
            rdn_d   = 1'b1;
            sts_d   = STS_OK;
            state_d = S_IDLE;
          end else begin
            bidx_d  = home_q;
            state_d = S_DET1;
          end
        end else if (sel == NO_SLOT) begin
          if (k_q == KW'(NUM_BUCKETS - 1)) begin
            valid_d = 1'b1;
            slot_d  = '0;
            hit_d   = 1'b0;
            rdn_d   = 1'b0;
            sts_d   = STS_NO_BUFFER;
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            bidx_d  = (bidx_q == BW'(NUM_BUCKETS - 1)) ? '0 : bidx_q + 1'b1;
            state_d = S_FSTRT;
          end
        end else begin
          ra      = AW'(sel);
          cur_d   = sel;
          state_d = S_FSCAN;
        end
      end
      S_DET1: begin
        if (p_q != NO_SLOT) begin
          wa    = AW'(p_q);
          we_lb = 1'b1;
        end else begin
          for (int b = 0; b < NUM_BUCKETS; b++) begin
            if (front_q[b] == cur_q) front_d[b] = n_q;
          end
        end
        state_d = S_DET2;
      end
      S_DET2: begin
        if (n_q != NO_SLOT) begin
          wa    = AW'(n_q);
          we_lf = 1'b1;
        end else begin
          for (int b = 0; b < NUM_BUCKETS; b++) begin
            if (back_q[b] == cur_q) back_d[b] = p_q;
          end
        end
        state_d = S_PUT1;
      end
      S_PUT1: begin
        old_d  = front_q[bidx_q];
        we_lb  = 1'b1;
        we_lf  = 1'b1;
        wd_lb  = front_q[bidx_q];
        wd_lf  = NO_SLOT;
        wd_cnt = CNT_W'(1);
        if (cmd_q == CMD_GET) begin
          we_tag = 1'b1;
          we_vld = 1'b1;
          we_cnt = 1'b1;
        end
        state_d = S_PUT2;
      end
      S_PUT2: begin
        if (old_q != NO_SLOT) begin
          wa    = AW'(old_q);
          we_lf = 1'b1;
          wd_lf = cur_q;
        end else begin
          back_d[bidx_q] = cur_q;
        end
        front_d[bidx_q] = cur_q;
        valid_d = 1'b1;
        slot_d  = IDX_W'(cur_q);
        hit_d   = 1'b0;
        rdn_d   = (cmd_q == CMD_GET);
        sts_d   = STS_OK;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      valid_q <= 1'b0;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        back_q[b] <= (b < NUM_SLOTS) ? SW'(b) : NO_SLOT;
        if (b >= NUM_SLOTS) front_q[b] <= NO_SLOT;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (i + NUM_BUCKETS >= NUM_SLOTS) front_q[BW'(i % NUM_BUCKETS)] <= SW'(i);
      end
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      valid_q <= valid_d;
      front_q <= front_d;
      back_q  <= back_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    dev_q  <= dev_d;
    blk_q  <= blk_d;
    cur_q  <= cur_d;
    p_q    <= p_d;
    n_q    <= n_d;
    old_q  <= old_d;
    home_q <= home_d;
    bidx_q <= bidx_d;
    k_q    <= k_d;
    hv_q   <= hv_d;
    hr_q   <= hr_d;
    hcnt_q <= hcnt_d;
    hit_q  <= hit_d;
    rdn_q  <= rdn_d;
    slot_q <= slot_d;
    sts_q  <= sts_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign valid_o       = valid_q;
  assign buffer_slot_o = slot_q;
  assign hit_o         = hit_q;
  assign needs_read_o  = rdn_q;
  assign status_o      = sts_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || valid_o))
    else $error("accepted request did not occupy the block");

  a_clr_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !valid_o)
    else $error("result during memory sweep");

  a_nobuf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == STS_NO_BUFFER) |-> (buffer_slot_o == '0 && !hit_o && !needs_read_o))
    else $error("no-buffer result carries a slot");

  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && hit_o) |-> (status_o == STS_OK && cmd_q == CMD_GET))
    else $error("hit on a non-get transfer");

endmodule

FILE: bench/hashed_lru_buffer_cache_checker.sv
// Checker for the hashed LRU buffer cache tag store: watches request and
// result transfers, predicts each result and compares it field by field.
// Depends on hlbc_pkg.
module hashed_lru_buffer_cache_checker
  import hlbc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  logic [CMD_W-1:0] cmd_i,
  input  logic [DEV_W-1:0] device_id_i,
  input  logic [BLK_W-1:0] block_number_i,
  input  logic [IDX_W-1:0] slot_index_i,
  input  logic             valid_o,
  input  logic [IDX_W-1:0] buffer_slot_o,
  input  logic             hit_o,
  input  logic             needs_read_o,
  input  logic [STS_W-1:0] status_o,
  output int               mismatches,
  output int               pending
);

  localparam int SLOTS   = NUM_SLOTS_DEF;
  localparam int BUCKETS = NUM_BUCKETS_DEF;
  localparam logic [5:0] NONE = 6'(SLOTS);

  typedef struct packed {
    logic [IDX_W-1:0] slot;
    logic             hit;
    logic             rd;
    logic [STS_W-1:0] status;
  } lookup_t;

  logic [DEV_W-1:0] dev_tag [SLOTS];
  logic [BLK_W-1:0] blk_tag [SLOTS];
  logic             filled  [SLOTS];
  logic [CNT_W-1:0] refs    [SLOTS];
  logic [5:0]       nxt     [SLOTS];
  logic [5:0]       prv     [SLOTS];
  logic [5:0]       head    [BUCKETS];
  logic [5:0]       tail    [BUCKETS];
  lookup_t          awaited [$];

  function automatic void unlink(int s);
    logic [5:0] p, n;
    p = prv[s];
    n = nxt[s];
    if (p < NONE) nxt[p] = n;
    else for (int b = 0; b < BUCKETS; b++) if (head[b] == s) head[b] = n;
    if (n < NONE) prv[n] = p;
    else for (int b = 0; b < BUCKETS; b++) if (tail[b] == s) tail[b] = p;
    prv[s] = NONE;
    nxt[s] = NONE;
  endfunction

  function automatic void push_front(int s, int b);
    logic [5:0] old;
    old = head[b];
    prv[s] = NONE;
    nxt[s] = old;
    if (old < NONE) prv[old] = 6'(s);
    else tail[b] = 6'(s);
    head[b] = 6'(s);
  endfunction

  function automatic logic [5:0] least_recent_free(int b);
    logic [5:0] s;
    s = tail[b];
    for (int g = 0; g < SLOTS && s < NONE; g++) begin
      if (refs[s] == 0) return s;
      s = prv[s];
    end
    return NONE;
  endfunction

  function automatic void clear_store();
    for (int b = 0; b < BUCKETS; b++) begin
      head[b] = NONE;
      tail[b] = NONE;
    end
    for (int i = 0; i < SLOTS; i++) begin
      dev_tag[i] = '0;
      blk_tag[i] = '0;
      filled[i]  = 1'b0;
      refs[i]    = '0;
      push_front(i, i % BUCKETS);
    end
  endfunction

  function automatic lookup_t serve(logic [CMD_W-1:0] c, logic [DEV_W-1:0] d,
                                    logic [BLK_W-1:0] blk, logic [IDX_W-1:0] idx);
    lookup_t r;
    int home;
    logic [5:0] s, found;
    r = '{slot: idx, hit: 1'b0, rd: 1'b0, status: STS_OK};
    if (c == CMD_GET) begin
      home = int'(blk % BUCKETS);
      s = head[home];
      found = NONE;
      for (int g = 0; g < SLOTS && s < NONE; g++) begin
        if (dev_tag[s] == d && blk_tag[s] == blk) begin
          found = s;
          break;
        end
        s = nxt[s];
      end
      if (found < NONE) begin
        if (refs[found] < CNT_MAX) refs[found]++;
        r.hit = 1'b1;
      end else begin
        found = least_recent_free(home);
        if (found >= NONE) begin
          for (int k = 1; k < BUCKETS; k++) begin
            found = least_recent_free((home + k) % BUCKETS);
            if (found < NONE) begin
              unlink(found);
              push_front(found, home);
              break;
            end
          end
        end
        if (found < NONE) begin
          dev_tag[found] = d;
          blk_tag[found] = blk;
          filled[found]  = 1'b0;
          refs[found]    = 1;
        end
      end
      if (found < NONE) begin
        r.slot = found[IDX_W-1:0];
        r.rd = !filled[found];
        filled[found] = 1'b1;
      end else begin
        r.slot = '0;
        r.hit = 1'b0;
        r.status = STS_NO_BUFFER;
      end
    end else if (idx < SLOTS) begin
      if (c == CMD_PIN) begin
        if (refs[idx] < CNT_MAX) refs[idx]++;
      end else if (refs[idx] == 0) begin
        r.status = STS_UNDERFLOW;
      end else begin
        refs[idx]--;
        if (c == CMD_RELEASE && refs[idx] == 0) begin
          unlink(idx);
          push_front(idx, int'(blk_tag[idx] % BUCKETS));
        end
      end
    end
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
    clear_store();
  end

  always @(posedge clk_i) begin
    lookup_t e;
    if (rst_ni) begin
      if (valid_o) begin
        if (awaited.size() == 0) begin
          report("unexpected transfer, slot", buffer_slot_o, 0);
        end else begin
          e = awaited.pop_front();
          if (buffer_slot_o !== e.slot) report("buffer_slot", buffer_slot_o, e.slot);
          if (hit_o !== e.hit) report("hit", hit_o, e.hit);
          if (needs_read_o !== e.rd) report("needs_read", needs_read_o, e.rd);
          if (status_o !== e.status) report("status", status_o, e.status);
        end
      end
      if (start && !busy)
        awaited.push_back(serve(cmd_i, device_id_i, block_number_i, slot_index_i));
      pending = awaited.size();
    end
  end

endmodule

FILE: bench/hashed_lru_buffer_cache_test.sv
// Testbench top for the hashed LRU buffer cache tag store: drives directed
// and random requests in bursts and prints the verdict.
// Depends on hlbc_pkg, hashed_lru_buffer_cache and its checker.
module hashed_lru_buffer_cache_test;
  import hlbc_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [CMD_W-1:0] cmd_i = CMD_GET;
  logic [DEV_W-1:0] device_id_i = '0;
  logic [BLK_W-1:0] block_number_i = '0;
  logic [IDX_W-1:0] slot_index_i = '0;
  logic             valid_o;
  logic [IDX_W-1:0] buffer_slot_o;
  logic             hit_o;
  logic             needs_read_o;
  logic [STS_W-1:0] status_o;
  int               mismatches;
  int               pending;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  hashed_lru_buffer_cache u_top (.*);
  hashed_lru_buffer_cache_checker u_check (.*);

  logic [BLK_W-1:0] recent_blk [8];

  task automatic issue(logic [CMD_W-1:0] c, logic [DEV_W-1:0] d,
                       logic [BLK_W-1:0] b, logic [IDX_W-1:0] s);
    start          <= 1'b1;
    cmd_i          <= c;
    device_id_i    <= d;
    block_number_i <= b;
    slot_index_i   <= s;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic gap();
    start <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  initial begin
    int burst;
    logic [BLK_W-1:0] b;
    foreach (recent_blk[i]) recent_blk[i] = $urandom_range(0, 40);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    issue(CMD_GET, 8'd0, 32'd0, '0);
    issue(CMD_GET, 8'd0, 32'd0, '0);
    issue(CMD_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31);
    issue(CMD_RELEASE, 8'd0, 32'd0, 5'd0);
    issue(CMD_RELEASE, 8'd0, 32'd0, 5'd0);
    issue(CMD_UNPIN, 8'd0, 32'd0, 5'd7);
    issue(CMD_RELEASE, 8'd0, 32'd0, 5'd31);
    for (int i = 0; i < 256; i++) issue(CMD_PIN, 8'd0, 32'd0, 5'd1);
    gap();
    issue(CMD_UNPIN, 8'd0, 32'd0, 5'd1);
    for (int i = 0; i < 34; i++) issue(CMD_GET, 8'h5A, 32'(i * 13 + 4), '0);
    gap();
    for (int i = 0; i < 32; i++) issue(CMD_RELEASE, 8'd0, 32'd0, 5'(i));
    for (int i = 0; i < 32; i++) issue(CMD_UNPIN, 8'd0, 32'd0, 5'(i));
    for (int n = 0; n < 140;) begin
      burst = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 20);
      for (int k = 0; k < burst; k++, n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            b = ($urandom_range(0, 4) == 0) ? $urandom() : recent_blk[$urandom_range(0, 7)];
            issue(CMD_GET, ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'd1, b, '0);
            recent_blk[$urandom_range(0, 7)] =
              ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : b;
          end
          4, 5, 6: issue(CMD_RELEASE, 8'($urandom()), $urandom(), 5'($urandom()));
          7: issue(CMD_PIN, 8'($urandom()), $urandom(), 5'($urandom()));
          default: issue(CMD_UNPIN, 8'($urandom()), $urandom(), 5'($urandom()));
        endcase
      end
      gap();
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: hashed_lru_buffer_cache.f
rtl/hlbc_pkg.sv
rtl/hashed_lru_buffer_cache.sv
bench/hashed_lru_buffer_cache_checker.sv
bench/hashed_lru_buffer_cache_test.sv
